@@ rtl/adh_pkg.sv @@
`default_nettype none

package adh_pkg;

    localparam int FRACTION_BITS = 16;
    localparam longint ONE_L = longint'(1) << FRACTION_BITS;
    localparam logic signed [31:0] ONE = 32'(ONE_L);

    localparam logic signed [31:0] S32MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32MIN = 32'sh8000_0000;

    // 142.0, the sodium level at which osmotic drive reaches one
    localparam logic signed [32:0] SODIUM_TOP = 33'(142 * ONE_L);

    // exp approximation constants, Q30
    localparam logic [30:0] Q30   = 31'h4000_0000;
    localparam logic [30:0] LOG2B = 31'd1549092360;
    localparam logic [29:0] LN2   = 30'd744261118;
    localparam int HORNER_STEPS   = 8;

    // shared divider and multiplier widths
    localparam int DIV_W  = 66;
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    localparam int QUEUE_DEPTH = 2;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SODIUM_REF   = 3'd0,
        REG_PRESSURE_UL  = 3'd1,
        REG_PRESSURE_GN  = 3'd2,
        REG_INV_TC       = 3'd3,
        REG_KIDNEY_LL    = 3'd4,
        REG_KIDNEY_UL    = 3'd5,
        REG_VASCULAR_LL  = 3'd6,
        REG_VASCULAR_UL  = 3'd7
    } cfg_index_t;

    localparam logic [31:0] RST_SODIUM_REF  = 32'(139 * ONE_L);
    localparam logic [31:0] RST_PRESSURE_UL = 32'(85 * ONE_L);
    localparam logic [31:0] RST_PRESSURE_GN = 32'((3 * ONE_L + 5) / 10);
    localparam logic [30:0] RST_INV_TC      = 31'(ONE_L);
    localparam logic [31:0] RST_KIDNEY_LL   = 32'((8 * ONE_L + 5) / 10);
    localparam logic [31:0] RST_KIDNEY_UL   = 32'(3 * ONE_L);
    localparam logic [31:0] RST_VASCULAR_LL = 32'((8 * ONE_L + 5) / 10);
    localparam logic [31:0] RST_VASCULAR_UL = 32'((14 * ONE_L + 5) / 10);

    typedef struct packed {
        logic signed [31:0] sodium_reference;
        logic signed [31:0] pressure_upper_limit;
        logic signed [31:0] pressure_gain;
        logic        [30:0] inverse_time_constant;
        logic signed [31:0] kidney_lower_limit;
        logic signed [31:0] kidney_upper_limit;
        logic signed [31:0] vascular_lower_limit;
        logic signed [31:0] vascular_upper_limit;
    } cfg_t;

    // one classified item as it waits for the back end
    typedef struct packed {
        logic signed [32:0] osm_num;
        logic        [31:0] deficit;
        logic signed [31:0] infusion;
        logic        [30:0] step;
    } job_t;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] num;
        logic signed [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [31:0] quotient;
        logic               sat;
    } div_rsp_t;

    // signed division by ONE, rounding toward zero
    function automatic logic signed [PROD_W-1:0] trunc_frac(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] bias;
        bias = p[PROD_W-1] ? PROD_W'(ONE_L - 1) : '0;
        return (p + bias) >>> FRACTION_BITS;
    endfunction

endpackage

`default_nettype wire

@@ rtl/adh_in_if.sv @@
`default_nettype none

interface adh_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sodium_level;
    logic signed [31:0] arterial_pressure;
    logic signed [31:0] infusion_rate;
    logic        [30:0] step_size;

    modport source (
        output valid, sodium_level, arterial_pressure, infusion_rate, step_size,
        input  ready
    );
    modport sink (
        input  valid, sodium_level, arterial_pressure, infusion_rate, step_size,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/adh_out_if.sv @@
`default_nettype none

interface adh_out_if;
    logic               valid;
    logic               ready;
    logic        [30:0] production_level;
    logic signed [31:0] smoothed_level;
    logic signed [31:0] kidney_multiplier;
    logic signed [31:0] vascular_multiplier;
    logic               saturated;

    modport source (
        output valid, production_level, smoothed_level, kidney_multiplier,
               vascular_multiplier, saturated,
        input  ready
    );
    modport sink (
        input  valid, production_level, smoothed_level, kidney_multiplier,
               vascular_multiplier, saturated,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/adh_front.sv @@
`default_nettype none

module adh_front (
    input  adh_pkg::cfg_t cfg,
    adh_in_if.sink        item,
    input  logic          full,
    output logic          push,
    output adh_pkg::job_t job
);

    logic signed [31:0] pressure_clamped;
    logic signed [32:0] deficit_w;

    assign item.ready = !full;
    assign push       = item.valid && !full;

    always_comb
    begin
        // hold pressure at the upper limit
        pressure_clamped = (item.arterial_pressure > cfg.pressure_upper_limit)
                         ? cfg.pressure_upper_limit : item.arterial_pressure;
        deficit_w = {cfg.pressure_upper_limit[31], cfg.pressure_upper_limit}
                  - {pressure_clamped[31], pressure_clamped};
        job.osm_num  = {item.sodium_level[31], item.sodium_level}
                     - {cfg.sodium_reference[31], cfg.sodium_reference};
        job.deficit  = deficit_w[31:0];
        job.infusion = item.infusion_rate;
        job.step     = item.step_size;
    end

endmodule

`default_nettype wire

@@ rtl/adh_queue.sv @@
`default_nettype none

module adh_queue #(
    parameter int DEPTH = adh_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  adh_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output adh_pkg::job_t pop_job,
    output logic          empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    adh_pkg::job_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue read while empty");

endmodule

`default_nettype wire

@@ rtl/adh_divider.sv @@
`default_nettype none

module adh_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  adh_pkg::div_req_t req,
    output adh_pkg::div_rsp_t rsp
);

    localparam int DW    = adh_pkg::DIV_W;
    localparam int MW    = DW - 1;
    localparam int ITER  = (MW + 1) / 2;
    localparam int QW    = 2 * ITER;
    localparam int CNT_W = $clog2(ITER + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MW-1:0]    rem_reg;
    logic [QW-1:0]    quo_reg;
    logic [MW-1:0]    dmag_reg;
    logic             neg_reg;
    logic signed [31:0] q_reg;
    logic             sat_reg;

    logic [MW-1:0]    rem_v;
    logic [QW-1:0]    quo_v;
    logic [MW:0]      shifted;
    logic [DW-1:0]    num_abs;
    logic [DW-1:0]    den_abs;
    logic signed [31:0] q_fin;
    logic             sat_fin;

    always_comb
    begin
        num_abs = req.num[DW-1] ? DW'(-req.num) : DW'(req.num);
        den_abs = req.den[DW-1] ? DW'(-req.den) : DW'(req.den);
    end

    // two restoring steps a cycle
    always_comb
    begin
        rem_v   = rem_reg;
        quo_v   = quo_reg;
        shifted = '0;
        for (int i = 0; i < 2; i++)
        begin
            shifted = {rem_v, quo_v[QW-1]};
            quo_v   = {quo_v[QW-2:0], 1'b0};
            if (shifted >= {1'b0, dmag_reg})
            begin
                shifted  = shifted - {1'b0, dmag_reg};
                quo_v[0] = 1'b1;
            end
            rem_v = shifted[MW-1:0];
        end
    end

    always_comb
    begin
        q_fin   = quo_v[31:0];
        sat_fin = 1'b0;
        if (!neg_reg)
        begin
            if (quo_v > QW'(adh_pkg::S32MAX))
            begin
                q_fin   = adh_pkg::S32MAX;
                sat_fin = 1'b1;
            end
        end
        else if (quo_v > QW'(33'h0_8000_0000))
        begin
            q_fin   = adh_pkg::S32MIN;
            sat_fin = 1'b1;
        end
        else
        begin
            q_fin = -quo_v[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= '0;
                if (req.den == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ITER - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= '0;
            quo_reg  <= QW'(num_abs[MW-1:0]);
            dmag_reg <= den_abs[MW-1:0];
            neg_reg  <= req.num[DW-1] ^ req.den[DW-1];
            if (req.den == '0)
            begin
                sat_reg <= 1'b1;
                if (req.num == '0)
                begin
                    q_reg <= '0;
                end
                else
                begin
                    q_reg <= req.num[DW-1] ? adh_pkg::S32MIN : adh_pkg::S32MAX;
                end
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_v;
            quo_reg <= quo_v;
            if (cnt_reg == CNT_W'(ITER - 1))
            begin
                q_reg   <= q_fin;
                sat_reg <= sat_fin;
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;
    assign rsp.sat      = sat_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("division started while busy");

endmodule

`default_nettype wire

@@ rtl/adh_back.sv @@
`default_nettype none

module adh_back (
    input  logic              clk,
    input  logic              rst_n,
    input  adh_pkg::cfg_t     cfg,
    input  logic              empty,
    input  adh_pkg::job_t     job,
    output logic              pop,
    output adh_pkg::div_req_t div_req,
    input  adh_pkg::div_rsp_t div_rsp,
    adh_out_if.source         result
);

    localparam int FB  = adh_pkg::FRACTION_BITS;
    localparam int DW  = adh_pkg::DIV_W;
    localparam int MW  = adh_pkg::MUL_W;
    localparam int PW  = adh_pkg::PROD_W;
    localparam int SQH = 32 - FB;
    localparam int XW  = 62 - FB;
    localparam logic [XW-1:0] X_LIMIT = XW'(longint'(32) << FB);
    localparam logic [FB:0]   FACTOR_ONE = (FB + 1)'(adh_pkg::ONE_L);

    typedef enum logic [23:0] {
        S_IDLE     = 24'h000001,
        S_OSM_DIV  = 24'h000002,
        S_OSM_WAIT = 24'h000004,
        S_SQ       = 24'h000008,
        S_PLO      = 24'h000010,
        S_PHI      = 24'h000020,
        S_DRV      = 24'h000040,
        S_SUM      = 24'h000080,
        S_X        = 24'h000100,
        S_Y        = 24'h000200,
        S_Z        = 24'h000400,
        S_ZS       = 24'h000800,
        S_HM       = 24'h001000,
        S_HD       = 24'h002000,
        S_HW       = 24'h004000,
        S_POW      = 24'h008000,
        S_SMOOTH   = 24'h010000,
        S_CONC     = 24'h020000,
        S_AD       = 24'h040000,
        S_AW       = 24'h080000,
        S_BM       = 24'h100000,
        S_BD       = 24'h200000,
        S_BW       = 24'h400000,
        S_OUT      = 24'h800000
    } state_t;

    state_t state_reg, state_next;

    adh_pkg::job_t      job_reg;
    logic signed [31:0] osm_reg;
    logic signed [PW-1:0] prod_reg;
    logic        [63:0] lo_reg;
    logic      [SQH-1:0] sqhi_reg;
    logic signed [31:0] drive_reg;
    logic        [30:0] level_reg;
    logic        [5:0]  n_reg;
    logic        [29:0] z_reg;
    logic        [30:0] t_reg;
    logic        [3:0]  k_reg;
    logic        [FB:0] factor_reg;
    logic signed [31:0] conc_reg;
    logic signed [31:0] a_reg;
    logic               sel_reg;
    logic signed [31:0] kid_reg;
    logic signed [31:0] vas_reg;
    logic               sat_reg;

    logic               out_valid_reg;
    logic        [30:0] out_level_reg;
    logic signed [31:0] out_smooth_reg;
    logic signed [31:0] out_kid_reg;
    logic signed [31:0] out_vas_reg;
    logic               out_sat_reg;

    logic signed [MW-1:0] ma, mb;
    logic signed [PW-1:0] prod_next;
    logic        [31:0] ag;
    logic        [95:0] full_w;
    logic        [95:0] m_w;
    logic signed [31:0] drive_w;
    logic               drive_sat;
    logic signed [33:0] sum_w;
    logic      [XW-1:0] x_w;
    logic        [35:0] y_w;
    logic        [30:0] power_w;
    logic        [30:0] one_minus;
    logic signed [33:0] diff_w;
    logic signed [32:0] cm_w;
    logic signed [PW-1:0] b_w;
    logic signed [PW-1:0] step_w;
    logic signed [31:0] lower, upper;
    logic signed [32:0] lower33, upper33;
    logic signed [32:0] m_mult;
    logic signed [31:0] mult_res;
    logic               mult_sat;
    logic               out_load;
    logic        [32:0] recip_w;

    function automatic logic signed [DW-1:0] scale_num(input logic signed [32:0] v);
        logic signed [DW-1:0] w;
        w = {{(DW-33){v[32]}}, v};
        return w <<< FB;
    endfunction

    // ceil(2^32 / k): multiply and take the top bits for an exact floor(v / k), v < 2^30
    function automatic logic [32:0] horner_recip(input logic [3:0] k);
        logic [32:0] r;
        case (k)
            4'd1:    r = 33'd4294967296;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655766;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993460;
            4'd6:    r = 33'd715827883;
            4'd7:    r = 33'd613566757;
            4'd8:    r = 33'd536870912;
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        ag      = cfg.pressure_gain[31] ? 32'(-cfg.pressure_gain) : 32'(cfg.pressure_gain);
        lower   = sel_reg ? cfg.vascular_lower_limit : cfg.kidney_lower_limit;
        upper   = sel_reg ? cfg.vascular_upper_limit : cfg.kidney_upper_limit;
        lower33 = {lower[31], lower};
        upper33 = {upper[31], upper};
        recip_w = horner_recip(k_reg);

        full_w  = {prod_reg[63:0], 32'h0} + {32'h0, lo_reg};
        m_w     = full_w >> FB;
        drive_w   = 32'(m_w);
        drive_sat = 1'b0;
        if (!cfg.pressure_gain[31])
        begin
            if (m_w > 96'(adh_pkg::S32MAX))
            begin
                drive_w   = adh_pkg::S32MAX;
                drive_sat = 1'b1;
            end
        end
        else if (m_w > 96'h8000_0000)
        begin
            drive_w   = adh_pkg::S32MIN;
            drive_sat = 1'b1;
        end
        else
        begin
            drive_w = -(32'(m_w));
        end

        sum_w = {{2{osm_reg[31]}}, osm_reg} + {{2{drive_reg[31]}}, drive_reg}
              + {{2{job_reg.infusion[31]}}, job_reg.infusion};

        x_w = prod_reg[61:FB];
        y_w = prod_reg[FB+35:FB];

        power_w   = (n_reg >= 6'd31) ? '0 : (t_reg >> n_reg);
        one_minus = adh_pkg::Q30 - power_w;

        diff_w = {3'b000, level_reg} - {{2{conc_reg[31]}}, conc_reg};
        cm_w   = {conc_reg[31], conc_reg} - {1'b0, adh_pkg::ONE};
        b_w    = adh_pkg::trunc_frac(prod_reg) + PW'(adh_pkg::ONE);
        step_w = adh_pkg::trunc_frac(prod_reg);

        m_mult   = upper33 - {div_rsp.quotient[31], div_rsp.quotient};
        mult_sat = 1'b0;
        if (m_mult < lower33)
        begin
            mult_res = lower;
        end
        else if (m_mult > 33'sh0_7FFF_FFFF)
        begin
            mult_res = adh_pkg::S32MAX;
            mult_sat = 1'b1;
        end
        else
        begin
            mult_res = m_mult[31:0];
        end
    end

    // shared multiplier operand selection
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            S_SQ:
            begin
                ma = {2'b00, job_reg.deficit};
                mb = {2'b00, job_reg.deficit};
            end
            S_PLO:
            begin
                ma = {2'b00, prod_reg[FB+31:FB]};
                mb = {2'b00, ag};
            end
            S_PHI:
            begin
                ma = MW'(sqhi_reg);
                mb = {2'b00, ag};
            end
            S_X:
            begin
                ma = {3'b000, job_reg.step};
                mb = {3'b000, cfg.inverse_time_constant};
            end
            S_Y:
            begin
                ma = {4'b0000, x_w[29:0]};
                mb = {3'b000, adh_pkg::LOG2B};
            end
            S_Z:
            begin
                ma = {4'b0000, y_w[29:0]};
                mb = {4'b0000, adh_pkg::LN2};
            end
            S_HM:
            begin
                ma = {4'b0000, z_reg};
                mb = {3'b000, t_reg};
            end
            S_HD:
            begin
                ma = {4'b0000, prod_reg[59:30]};
                mb = {1'b0, recip_w};
            end
            S_SMOOTH:
            begin
                ma = diff_w;
                mb = MW'(factor_reg);
            end
            S_BM:
            begin
                ma = {{2{a_reg[31]}}, a_reg};
                mb = {cm_w[32], cm_w};
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
        prod_next = ma * mb;
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next    = state_reg;
        pop           = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = S_OSM_DIV;
                end
            end
            S_OSM_DIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = scale_num(job_reg.osm_num);
                div_req.den   = DW'($signed(adh_pkg::SODIUM_TOP
                              - {cfg.sodium_reference[31], cfg.sodium_reference}));
                state_next    = S_OSM_WAIT;
            end
            S_OSM_WAIT: if (div_rsp.done) state_next = S_SQ;
            S_SQ:       state_next = S_PLO;
            S_PLO:      state_next = S_PHI;
            S_PHI:      state_next = S_DRV;
            S_DRV:      state_next = S_SUM;
            S_SUM:      state_next = S_X;
            S_X:        state_next = S_Y;
            S_Y:        state_next = (x_w >= X_LIMIT) ? S_SMOOTH : S_Z;
            S_Z:        state_next = S_ZS;
            S_ZS:       state_next = S_HM;
            S_HM:       state_next = S_HD;
            S_HD:       state_next = S_HW;
            S_HW:       state_next = (k_reg == 4'd1) ? S_POW : S_HM;
            S_POW:      state_next = S_SMOOTH;
            S_SMOOTH:   state_next = S_CONC;
            S_CONC:     state_next = S_AD;
            S_AD:
            begin
                div_req.start = 1'b1;
                div_req.num   = scale_num(lower33 - {1'b0, adh_pkg::ONE});
                div_req.den   = DW'(lower33 - upper33);
                state_next    = S_AW;
            end
            S_AW:       if (div_rsp.done) state_next = S_BM;
            S_BM:       state_next = S_BD;
            S_BD:
            begin
                div_req.start = 1'b1;
                div_req.num   = scale_num(upper33 - {1'b0, adh_pkg::ONE});
                div_req.den   = b_w[DW-1:0];
                state_next    = S_BW;
            end
            S_BW:
            begin
                if (div_rsp.done)
                begin
                    state_next = sel_reg ? S_OUT : S_AD;
                end
            end
            S_OUT:      if (out_load) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            conc_reg      <= adh_pkg::ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CONC)
            begin
                conc_reg <= conc_reg + step_w[31:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (state_reg)
            S_IDLE:
            begin
                job_reg <= job;
                sat_reg <= 1'b0;
            end
            S_OSM_WAIT:
            begin
                if (div_rsp.done)
                begin
                    osm_reg <= div_rsp.quotient[31] ? '0 : div_rsp.quotient;
                    sat_reg <= sat_reg | div_rsp.sat;
                end
            end
            S_PLO:      sqhi_reg <= prod_reg[63:FB+32];
            S_PHI:      lo_reg   <= prod_reg[63:0];
            S_DRV:
            begin
                drive_reg <= drive_w;
                sat_reg   <= sat_reg | drive_sat;
            end
            S_SUM:
            begin
                if (sum_w[33])
                begin
                    level_reg <= '0;
                end
                else if (sum_w > 34'sh0_7FFF_FFFF)
                begin
                    level_reg <= 31'h7FFF_FFFF;
                    sat_reg   <= 1'b1;
                end
                else
                begin
                    level_reg <= sum_w[30:0];
                end
            end
            S_Y:        if (x_w >= X_LIMIT) factor_reg <= FACTOR_ONE;
            S_Z:        n_reg <= y_w[35:30];
            S_ZS:
            begin
                z_reg <= prod_reg[59:30];
                t_reg <= adh_pkg::Q30;
                k_reg <= 4'(adh_pkg::HORNER_STEPS);
            end
            S_HW:
            begin
                t_reg <= adh_pkg::Q30 - {1'b0, prod_reg[61:32]};
                k_reg <= k_reg - 1'b1;
            end
            S_POW:      factor_reg <= one_minus[30:30-FB];
            S_CONC:     sel_reg <= 1'b0;
            S_AW:
            begin
                if (div_rsp.done)
                begin
                    a_reg   <= div_rsp.quotient;
                    sat_reg <= sat_reg | div_rsp.sat;
                end
            end
            S_BW:
            begin
                if (div_rsp.done)
                begin
                    sat_reg <= sat_reg | div_rsp.sat | mult_sat;
                    if (sel_reg)
                    begin
                        vas_reg <= mult_res;
                    end
                    else
                    begin
                        kid_reg <= mult_res;
                        sel_reg <= 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_level_reg  <= level_reg;
            out_smooth_reg <= conc_reg;
            out_kid_reg    <= kid_reg;
            out_vas_reg    <= vas_reg;
            out_sat_reg    <= sat_reg;
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.production_level    = out_level_reg;
    assign result.smoothed_level      = out_smooth_reg;
    assign result.kidney_multiplier   = out_kid_reg;
    assign result.vascular_multiplier = out_vas_reg;
    assign result.saturated           = out_sat_reg;

    a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SMOOTH) |-> (factor_reg <= FACTOR_ONE))
        else $error("smoothing factor above one");
    a_idle_divider: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_rsp.busy)
        else $error("divider busy between items");

endmodule

`default_nettype wire

@@ rtl/adh_hormone_effect_step.sv @@
// The back end works on one item at a time and pops the next one only after
// the last result has been loaded into the output register. The shared divider
// (two quotient bits a cycle) does five divisions per item.
// A two-entry queue and an output register let input and output stall apart.
// Reset: registers take their default values and the concentration is 1.0.
`default_nettype none

module adh_hormone_effect_step #(
    parameter int QUEUE_DEPTH = adh_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [adh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    adh_in_if.sink                        item,
    adh_out_if.source                     result
);

    adh_pkg::cfg_t     cfg_reg;
    adh_pkg::job_t     front_job;
    adh_pkg::job_t     queue_job;
    adh_pkg::div_req_t div_req;
    adh_pkg::div_rsp_t div_rsp;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sodium_reference      <= adh_pkg::RST_SODIUM_REF;
            cfg_reg.pressure_upper_limit  <= adh_pkg::RST_PRESSURE_UL;
            cfg_reg.pressure_gain         <= adh_pkg::RST_PRESSURE_GN;
            cfg_reg.inverse_time_constant <= adh_pkg::RST_INV_TC;
            cfg_reg.kidney_lower_limit    <= adh_pkg::RST_KIDNEY_LL;
            cfg_reg.kidney_upper_limit    <= adh_pkg::RST_KIDNEY_UL;
            cfg_reg.vascular_lower_limit  <= adh_pkg::RST_VASCULAR_LL;
            cfg_reg.vascular_upper_limit  <= adh_pkg::RST_VASCULAR_UL;
        end
        else if (cfg_we)
        begin
            unique case (adh_pkg::cfg_index_t'(cfg_index))
                adh_pkg::REG_SODIUM_REF:  cfg_reg.sodium_reference      <= cfg_data;
                adh_pkg::REG_PRESSURE_UL: cfg_reg.pressure_upper_limit  <= cfg_data;
                adh_pkg::REG_PRESSURE_GN: cfg_reg.pressure_gain         <= cfg_data;
                adh_pkg::REG_INV_TC:      cfg_reg.inverse_time_constant <= cfg_data[30:0];
                adh_pkg::REG_KIDNEY_LL:   cfg_reg.kidney_lower_limit    <= cfg_data;
                adh_pkg::REG_KIDNEY_UL:   cfg_reg.kidney_upper_limit    <= cfg_data;
                adh_pkg::REG_VASCULAR_LL: cfg_reg.vascular_lower_limit  <= cfg_data;
                adh_pkg::REG_VASCULAR_UL: cfg_reg.vascular_upper_limit  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    adh_front u_front (
        .cfg  (cfg_reg),
        .item (item),
        .full (full),
        .push (push),
        .job  (front_job)
    );

    adh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (queue_job),
        .empty    (empty)
    );

    adh_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    adh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .empty   (empty),
        .job     (queue_job),
        .pop     (pop),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ verif/adh_hormone_effect_step_tb.sv @@
`timescale 1ns / 100ps

module adh_hormone_effect_step_tb;

    typedef struct {
        logic signed [31:0] sodium;
        logic signed [31:0] pressure;
        logic signed [31:0] infusion;
        logic        [30:0] step;
    } adh_item_t;

    typedef struct {
        logic        [30:0] production;
        logic signed [31:0] smoothed;
        logic signed [31:0] kidney;
        logic signed [31:0] vascular;
        logic               sat;
    } adh_result_t;

    localparam longint QONE     = longint'(1) << 16;
    localparam longint MAX_S32  = 64'sd2147483647;
    localparam longint MIN_S32  = -64'sd2147483648;
    localparam longint unsigned Q30_L   = 64'd1 << 30;
    localparam longint unsigned LOG2B_L = 64'd1549092360;
    localparam longint unsigned LN2_L   = 64'd744261118;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    adh_in_if  in_ch ();
    adh_out_if out_ch ();

    adh_hormone_effect_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (in_ch),
        .result    (out_ch)
    );

    adh_item_t   pending_steps[$];
    adh_result_t expected_results[$];
    logic signed [31:0] reg_shadow[8];
    longint      concentration;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_send = 1'b0;
    bit          failed = 1'b0;
    int          quiet_cycles = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic longint clamp_s32(longint v, inout bit sat);
        if (v > MAX_S32) begin
            sat = 1'b1;
            return MAX_S32;
        end
        if (v < MIN_S32) begin
            sat = 1'b1;
            return MIN_S32;
        end
        return v;
    endfunction

    function automatic longint fixed_div(longint num, longint den, inout bit sat);
        if (den == 0) begin
            sat = 1'b1;
            return num > 0 ? MAX_S32 : (num < 0 ? MIN_S32 : 0);
        end
        return clamp_s32((num * QONE) / den, sat);
    endfunction

    function automatic longint decay_factor(longint unsigned step, longint unsigned inv);
        longint unsigned x, y, f, z, t, power;
        longint unsigned n;
        x = (step * inv) >> 16;
        if (x >= (64'd32 << 16))
            return QONE;
        y = (x * LOG2B_L) >> 16;
        n = y >> 30;
        f = y & (Q30_L - 1);
        z = (f * LN2_L) >> 30;
        t = Q30_L;
        for (int k = 8; k >= 1; k--)
            t = Q30_L - ((z * t) >> 30) / k;
        power = (n >= 31) ? 0 : (t >> n);
        return longint'((Q30_L - power) >> 14);
    endfunction

    function automatic longint effect_multiplier(longint lower, longint upper, longint c,
                                                 inout bit sat);
        longint a, b, m;
        a = fixed_div(lower - QONE, lower - upper, sat);
        b = (a * (c - QONE)) / QONE + QONE;
        m = upper - fixed_div(upper - QONE, b, sat);
        if (m < lower)
            return lower;
        return clamp_s32(m, sat);
    endfunction

    // advance the concentration by one time step and work out the result
    function automatic adh_result_t hormone_step(adh_item_t it);
        adh_result_t r;
        bit sat;
        longint cnr, pul, gain, pa, osm, drive, sum, prod, fac;
        longint unsigned d, sq, ag, m;
        sat  = 1'b0;
        cnr  = reg_shadow[adh_pkg::REG_SODIUM_REF];
        pul  = reg_shadow[adh_pkg::REG_PRESSURE_UL];
        gain = reg_shadow[adh_pkg::REG_PRESSURE_GN];
        osm = fixed_div(longint'(it.sodium) - cnr, (longint'(142) << 16) - cnr, sat);
        if (osm < 0)
            osm = 0;
        pa = it.pressure;
        if (pa > pul)
            pa = pul;
        d  = pul - pa;
        sq = (d * d) >> 16;
        ag = (gain < 0) ? -gain : gain;
        if (ag != 0 && sq > 64'hFFFF_FFFF_FFFF_FFFF / ag)
            m = 64'd1 << 40;
        else
            m = (sq * ag) >> 16;
        if (gain >= 0) begin
            if (m > 64'd2147483647) begin
                sat = 1'b1;
                drive = MAX_S32;
            end
            else
                drive = m;
        end
        else begin
            if (m > 64'd2147483648) begin
                sat = 1'b1;
                drive = MIN_S32;
            end
            else
                drive = -longint'(m);
        end
        sum = osm + drive + longint'(it.infusion);
        if (sum < 0)
            prod = 0;
        else if (sum > MAX_S32) begin
            sat = 1'b1;
            prod = MAX_S32;
        end
        else
            prod = sum;
        fac = decay_factor(longint'(it.step),
                           longint'(reg_shadow[adh_pkg::REG_INV_TC][30:0]));
        concentration += ((prod - concentration) * fac) / QONE;
        r.production = prod[30:0];
        r.smoothed   = concentration[31:0];
        r.kidney     = effect_multiplier(reg_shadow[adh_pkg::REG_KIDNEY_LL],
                                         reg_shadow[adh_pkg::REG_KIDNEY_UL],
                                         concentration, sat);
        r.vascular   = effect_multiplier(reg_shadow[adh_pkg::REG_VASCULAR_LL],
                                         reg_shadow[adh_pkg::REG_VASCULAR_UL],
                                         concentration, sat);
        r.sat        = sat;
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        adh_item_t nxt;
        bit busy;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end
        else begin
            busy = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                nxt.sodium   = in_ch.sodium_level;
                nxt.pressure = in_ch.arterial_pressure;
                nxt.infusion = in_ch.infusion_rate;
                nxt.step     = in_ch.step_size;
                expected_results.push_back(hormone_step(nxt));
                busy = 1'b0;
            end
            if (!busy) begin
                if (pending_steps.size() > 0 && !hold_send &&
                    $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_steps.pop_front();
                    in_ch.valid             <= 1'b1;
                    in_ch.sodium_level      <= nxt.sodium;
                    in_ch.arterial_pressure <= nxt.pressure;
                    in_ch.infusion_rate     <= nxt.infusion;
                    in_ch.step_size         <= nxt.step;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n) begin
        adh_result_t want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end
        else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, got prod %h smooth %h", $time,
                             out_ch.production_level, out_ch.smoothed_level);
                    failed = 1'b1;
                end
                else begin
                    want = expected_results.pop_front();
                    if (out_ch.production_level !== want.production) begin
                        $display("%0t: production expected %h actual %h", $time,
                                 want.production, out_ch.production_level);
                        failed = 1'b1;
                    end
                    if (out_ch.smoothed_level !== want.smoothed) begin
                        $display("%0t: smoothed expected %h actual %h", $time,
                                 want.smoothed, out_ch.smoothed_level);
                        failed = 1'b1;
                    end
                    if (out_ch.kidney_multiplier !== want.kidney) begin
                        $display("%0t: kidney expected %h actual %h", $time,
                                 want.kidney, out_ch.kidney_multiplier);
                        failed = 1'b1;
                    end
                    if (out_ch.vascular_multiplier !== want.vascular) begin
                        $display("%0t: vascular expected %h actual %h", $time,
                                 want.vascular, out_ch.vascular_multiplier);
                        failed = 1'b1;
                    end
                    if (out_ch.saturated !== want.sat) begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.sat, out_ch.saturated);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // watchdog: any transaction on either side restarts the count
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(adh_pkg::cfg_index_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        reg_shadow[idx] = (idx == adh_pkg::REG_INV_TC) ? {1'b0, value[30:0]} : value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_regs(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                             logic [31:0] v3, logic [31:0] v4, logic [31:0] v5,
                             logic [31:0] v6, logic [31:0] v7);
        write_reg(adh_pkg::REG_SODIUM_REF, v0);
        write_reg(adh_pkg::REG_PRESSURE_UL, v1);
        write_reg(adh_pkg::REG_PRESSURE_GN, v2);
        write_reg(adh_pkg::REG_INV_TC, v3);
        write_reg(adh_pkg::REG_KIDNEY_LL, v4);
        write_reg(adh_pkg::REG_KIDNEY_UL, v5);
        write_reg(adh_pkg::REG_VASCULAR_LL, v6);
        write_reg(adh_pkg::REG_VASCULAR_UL, v7);
    endtask

    task automatic wait_drained();
        while (pending_steps.size() != 0 || expected_results.size() != 0 || in_ch.valid)
            @(posedge clk);
    endtask

    function automatic logic [31:0] q_units(int whole);
        return 32'(whole) << 16 | 32'($urandom_range(65535));
    endfunction

    task automatic push_step(logic [31:0] na, logic [31:0] pa, logic [31:0] inf,
                             logic [30:0] st);
        adh_item_t it;
        it.sodium = na;
        it.pressure = pa;
        it.infusion = inf;
        it.step = st;
        pending_steps.push_back(it);
    endtask

    // mostly physiological steps, the rest raw bit patterns
    task automatic push_random(int count);
        repeat (count) begin
            if ($urandom_range(9) < 7)
                push_step(q_units($urandom_range(125, 155)), q_units($urandom_range(20, 130)),
                          ($urandom_range(3) == 0) ? q_units($urandom_range(0, 4))
                                                   : 32'(-$urandom_range(0, 1 << 17)),
                          31'($urandom_range(0, 4 << 16)));
            else
                push_step($urandom, $urandom, $urandom, 31'($urandom));
        end
    endtask

    task automatic load_physiological();
        load_regs(q_units($urandom_range(130, 141)), q_units($urandom_range(70, 100)),
                  32'($urandom_range(0, 1 << 17)), 32'($urandom_range(1 << 12, 3 << 16)),
                  32'($urandom_range(1 << 15, 1 << 16)), q_units($urandom_range(1, 4)),
                  32'($urandom_range(1 << 15, 1 << 16)), q_units($urandom_range(1, 2)));
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.sodium_level = '0;
        in_ch.arterial_pressure = '0;
        in_ch.infusion_rate = '0;
        in_ch.step_size = '0;
        out_ch.ready = 1'b0;
        reg_shadow[adh_pkg::REG_SODIUM_REF]  = adh_pkg::RST_SODIUM_REF;
        reg_shadow[adh_pkg::REG_PRESSURE_UL] = adh_pkg::RST_PRESSURE_UL;
        reg_shadow[adh_pkg::REG_PRESSURE_GN] = adh_pkg::RST_PRESSURE_GN;
        reg_shadow[adh_pkg::REG_INV_TC]      = {1'b0, adh_pkg::RST_INV_TC};
        reg_shadow[adh_pkg::REG_KIDNEY_LL]   = adh_pkg::RST_KIDNEY_LL;
        reg_shadow[adh_pkg::REG_KIDNEY_UL]   = adh_pkg::RST_KIDNEY_UL;
        reg_shadow[adh_pkg::REG_VASCULAR_LL] = adh_pkg::RST_VASCULAR_LL;
        reg_shadow[adh_pkg::REG_VASCULAR_UL] = adh_pkg::RST_VASCULAR_UL;
        concentration = QONE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes under reset registers
        push_step(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0);
        push_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        push_step(32'd139 << 16, 32'd85 << 16, 32'h0, 31'h1_0000);
        push_step(32'd145 << 16, 32'd90 << 16, 32'h0, 31'h8000);
        push_step(32'd141 << 16, 32'd60 << 16, 32'h1_0000, 31'h20_0000);
        push_step(32'd142 << 16, 32'h0, 32'h0, 31'h1F_FFFF);
        push_step(32'h0, 32'h8000_0000, 32'h0, 31'h1);
        push_step(32'd140 << 16, 32'd70 << 16, 32'hFFFF_0000, 31'h4_0000);
        push_step(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        push_step(32'd138 << 16, 32'd85 << 16, 32'h8000_0000, 31'h1_0000);
        wait_drained();

        // division by zero on the osmotic drive, top gain, saturating step
        load_regs(32'd142 << 16, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'd2 << 16, 32'd2 << 16, 32'd1 << 16, 32'h7FFF_FFFF);
        push_step(32'd143 << 16, 32'h8000_0000, 32'h0, 31'h7FFF_FFFF);
        push_step(32'd141 << 16, 32'd10 << 16, 32'h0, 31'h1_0000);
        push_step(32'd142 << 16, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0);
        push_random(50);
        stall_pct = 81;
        wait_drained();

        // most negative gain, zero time constant, bottom sodium reference
        load_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        push_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 31'h7FFF_FFFF);
        push_random(50);
        stall_pct = 18;
        send_idle_pct = 18;
        wait_drained();

        load_regs(adh_pkg::RST_SODIUM_REF, adh_pkg::RST_PRESSURE_UL,
                  adh_pkg::RST_PRESSURE_GN, {1'b0, adh_pkg::RST_INV_TC},
                  adh_pkg::RST_KIDNEY_LL, adh_pkg::RST_KIDNEY_UL,
                  adh_pkg::RST_VASCULAR_LL, adh_pkg::RST_VASCULAR_UL);
        stall_pct = 0;
        send_idle_pct = 0;
        push_random(110);
        wait_drained();

        load_physiological();
        send_idle_pct = 81;
        push_random(110);
        wait_drained();

        load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
        send_idle_pct = 18;
        stall_pct = 18;
        push_random(60);
        wait_drained();

        // one step at a time: push a single step and wait until the block has drained
        load_physiological();
        send_idle_pct = 0;
        stall_pct = 81;
        repeat (8) begin
            hold_send = 1'b1;
            push_random(1);
            hold_send = 1'b0;
            wait_drained();
        end

        load_physiological();
        send_idle_pct = 18;
        stall_pct = 18;
        push_random(148);
        wait_drained();

        repeat (600) @(posedge clk);
        if (!failed && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ adh_hormone_effect_step.f @@
rtl/adh_pkg.sv
rtl/adh_in_if.sv
rtl/adh_out_if.sv
rtl/adh_front.sv
rtl/adh_queue.sv
rtl/adh_divider.sv
rtl/adh_back.sv
rtl/adh_hormone_effect_step.sv
verif/adh_hormone_effect_step_tb.sv
